// ===== rtl/ps2sc_pkg.sv =====
// Shared types, codes and key map tables for the PS/2 set-2 decoder.
`timescale 1ns / 1ps

package ps2sc_pkg;

   // Default character FIFO depth
   localparam int FIFO_DEPTH_DEF = 128;

   // Request operation codes
   localparam logic OP_SCAN = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Scan codes of interest (set 2)
   localparam logic [7:0] CODE_BREAK  = 8'hF0;
   localparam logic [7:0] CODE_LSHIFT = 8'h12;
   localparam logic [7:0] CODE_RSHIFT = 8'h59;
   localparam logic [7:0] CODE_LCTRL  = 8'h14;
   localparam logic [7:0] CODE_KEY_C  = 8'h21;
   localparam logic [7:0] CODE_KEY_D  = 8'h23;

   // Characters with special handling
   localparam logic [6:0] CHAR_EOT = 7'h04;
   localparam logic [6:0] CHAR_CR  = 7'h0D;
   localparam logic [6:0] CHAR_NUL = 7'h00;

   // Result beat, less the popped character
   typedef struct packed {
      logic       char_valid;
      logic       fifo_empty;
      logic [7:0] fill_count;
      logic       ctrl_c_event;
      logic       line_end;
      logic       overflow;
   } rsp_stat_type;

   // Unshifted key map, codes below 0x80
   function automatic logic [6:0] lower_map(input logic [6:0] code);
      logic [6:0] c;
      unique case (code)
         7'h15: c = 7'h71;  7'h16: c = 7'h31;  7'h1A: c = 7'h7A;  7'h1B: c = 7'h73;
         7'h1C: c = 7'h61;  7'h1D: c = 7'h77;  7'h1E: c = 7'h32;
         7'h21: c = 7'h63;  7'h22: c = 7'h78;  7'h23: c = 7'h64;  7'h24: c = 7'h65;
         7'h25: c = 7'h34;  7'h26: c = 7'h33;
         7'h29: c = 7'h20;  7'h2A: c = 7'h76;  7'h2B: c = 7'h66;  7'h2C: c = 7'h74;
         7'h2D: c = 7'h72;  7'h2E: c = 7'h35;
         7'h31: c = 7'h6E;  7'h32: c = 7'h62;  7'h33: c = 7'h68;  7'h34: c = 7'h67;
         7'h35: c = 7'h79;  7'h36: c = 7'h36;
         7'h3A: c = 7'h6D;  7'h3B: c = 7'h6A;  7'h3C: c = 7'h75;  7'h3D: c = 7'h37;
         7'h3E: c = 7'h38;
         7'h41: c = 7'h2C;  7'h42: c = 7'h6B;  7'h43: c = 7'h69;  7'h44: c = 7'h6F;
         7'h45: c = 7'h30;  7'h46: c = 7'h39;
         7'h49: c = 7'h2E;  7'h4A: c = 7'h2F;  7'h4B: c = 7'h6C;  7'h4C: c = 7'h3B;
         7'h4D: c = 7'h70;  7'h4E: c = 7'h2D;
         7'h52: c = 7'h27;  7'h54: c = 7'h5B;  7'h55: c = 7'h3D;  7'h5A: c = CHAR_CR;
         7'h5B: c = 7'h5D;  7'h5D: c = 7'h5C;  7'h66: c = 7'h08;
         default: c = CHAR_NUL;
      endcase
      return c;
   endfunction

   // Shifted key map, codes below 0x80
   function automatic logic [6:0] upper_map(input logic [6:0] code);
      logic [6:0] c;
      unique case (code)
         7'h15: c = 7'h51;  7'h16: c = 7'h21;  7'h1A: c = 7'h5A;  7'h1B: c = 7'h53;
         7'h1C: c = 7'h41;  7'h1D: c = 7'h57;  7'h1E: c = 7'h40;
         7'h21: c = 7'h43;  7'h22: c = 7'h58;  7'h23: c = 7'h44;  7'h24: c = 7'h45;
         7'h25: c = 7'h24;  7'h26: c = 7'h23;
         7'h29: c = 7'h20;  7'h2A: c = 7'h56;  7'h2B: c = 7'h46;  7'h2C: c = 7'h54;
         7'h2D: c = 7'h52;  7'h2E: c = 7'h25;
         7'h31: c = 7'h4E;  7'h32: c = 7'h42;  7'h33: c = 7'h48;  7'h34: c = 7'h47;
         7'h35: c = 7'h59;  7'h36: c = 7'h5E;
         7'h3A: c = 7'h4D;  7'h3B: c = 7'h4A;  7'h3C: c = 7'h55;  7'h3D: c = 7'h26;
         7'h3E: c = 7'h2A;
         7'h41: c = 7'h3C;  7'h42: c = 7'h4B;  7'h43: c = 7'h49;  7'h44: c = 7'h4F;
         7'h45: c = 7'h29;  7'h46: c = 7'h28;
         7'h49: c = 7'h3E;  7'h4A: c = 7'h3F;  7'h4B: c = 7'h4C;  7'h4C: c = 7'h3A;
         7'h4D: c = 7'h50;  7'h4E: c = 7'h5F;
         7'h52: c = 7'h22;  7'h54: c = 7'h7B;  7'h55: c = 7'h2B;  7'h5A: c = CHAR_CR;
         7'h5B: c = 7'h7D;  7'h5D: c = 7'h7C;  7'h66: c = 7'h08;
         default: c = CHAR_NUL;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/ps2sc_req_if.sv =====
// Request channel: scan byte or read request.
`timescale 1ns / 1ps

interface ps2sc_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] scan_code;

   modport source (output valid, operation, scan_code, input ready);
   modport sink   (input valid, operation, scan_code, output ready);
endinterface

// ===== rtl/ps2sc_rsp_if.sv =====
// Response channel: popped character and FIFO status.
`timescale 1ns / 1ps

interface ps2sc_rsp_if;
   logic       valid;
   logic       ready;
   logic       char_valid;
   logic [6:0] char_out;
   logic       fifo_empty;
   logic [7:0] fill_count;
   logic       ctrl_c_event;
   logic       line_end;
   logic       overflow;

   modport source (output valid, char_valid, char_out, fifo_empty, fill_count,
                   ctrl_c_event, line_end, overflow, input ready);
   modport sink   (input valid, char_valid, char_out, fifo_empty, fill_count,
                   ctrl_c_event, line_end, overflow, output ready);
endinterface

// ===== rtl/ps2_set2_scancode_to_ascii_fifo.sv =====
// Top level: PS/2 set-2 scan code decoder with a character FIFO.
`timescale 1ns / 1ps

// Usage:
//  req_ch carries one beat per item: operation 0 delivers a received scan
//  byte, operation 1 asks to pop one character. Every request beat yields
//  exactly one rsp_ch beat with the popped character (if any), the FIFO
//  fill after the item and the Ctrl-C, carriage return and overflow flags.
//  Throughput is one item per cycle while the receiver takes responses:
//  modifier flags, pointers and count update in the accept cycle, and the
//  character store has one write and one registered read port, each used
//  at most once per item.
//  A result stage and an output register follow the accept; while the
//  receiver stalls, one more request is still taken into the result stage,
//  after which req_ch.ready drops until rsp_ch.ready returns.
//  Reset clears the break, shift and control flags, the pointers and the
//  count, so the FIFO starts empty. Store contents are not cleared; only
//  written entries are ever read. A full FIFO drops new characters and flags
//  overflow; codes at or above 0x80 produce no character.
module ps2_set2_scancode_to_ascii_fifo #(
   parameter int FIFO_DEPTH = ps2sc_pkg::FIFO_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   ps2sc_req_if.sink          req_ch,
   ps2sc_rsp_if.source        rsp_ch
);

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

   // Character store
   logic [6:0] char_mem [FIFO_DEPTH];
   logic [6:0] rd_data_ff;

   // Decoder and FIFO control state
   logic             brk_ff, brk_in;
   logic             shift_ff, shift_in;
   logic             ctrl_ff, ctrl_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Result stage and output register
   logic                    p_valid_ff;
   ps2sc_pkg::rsp_stat_type p_res_ff, p_res_in;
   logic                    o_valid_ff;
   ps2sc_pkg::rsp_stat_type o_res_ff;
   logic [6:0]              o_char_ff;

   logic       accept;
   logic       p_adv;
   logic       push, pop;
   logic       want_push;
   logic [6:0] push_char;
   logic [6:0] map_char;
   logic       full;

   // Handshake
   assign p_adv        = p_valid_ff && (!o_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !p_valid_ff || p_adv;
   assign accept       = req_ch.valid && req_ch.ready;
   assign full         = (cnt_ff == CNT_FULL);

   assign map_char = shift_ff ? ps2sc_pkg::upper_map(req_ch.scan_code[6:0])
                              : ps2sc_pkg::lower_map(req_ch.scan_code[6:0]);

   // Key decode and FIFO bookkeeping
   always_comb begin
      brk_in    = brk_ff;
      shift_in  = shift_ff;
      ctrl_in   = ctrl_ff;
      want_push = 1'b0;
      push_char = map_char;
      pop       = 1'b0;
      p_res_in  = '0;

      if (accept) begin
         if (req_ch.operation == ps2sc_pkg::OP_READ) begin
            pop = (cnt_ff != '0);
         end else if (req_ch.scan_code == ps2sc_pkg::CODE_BREAK) begin
            brk_in = 1'b1;
         end else if (brk_ff) begin
            if (req_ch.scan_code == ps2sc_pkg::CODE_LSHIFT ||
                req_ch.scan_code == ps2sc_pkg::CODE_RSHIFT) begin
               shift_in = 1'b0;
            end
            if (req_ch.scan_code == ps2sc_pkg::CODE_LCTRL) begin
               ctrl_in = 1'b0;
            end
            brk_in = 1'b0;
         end else if (req_ch.scan_code == ps2sc_pkg::CODE_LSHIFT ||
                      req_ch.scan_code == ps2sc_pkg::CODE_RSHIFT) begin
            shift_in = 1'b1;
         end else if (req_ch.scan_code == ps2sc_pkg::CODE_LCTRL) begin
            ctrl_in = 1'b1;
         end else if (ctrl_ff && req_ch.scan_code == ps2sc_pkg::CODE_KEY_C) begin
            ctrl_in               = 1'b0;
            p_res_in.ctrl_c_event = 1'b1;
         end else if (ctrl_ff && req_ch.scan_code == ps2sc_pkg::CODE_KEY_D) begin
            want_push = 1'b1;
            push_char = ps2sc_pkg::CHAR_EOT;
         end else if (!req_ch.scan_code[7]) begin
            want_push = (map_char != ps2sc_pkg::CHAR_NUL);
         end
      end

      push              = want_push && !full;
      p_res_in.overflow = want_push && full;
      p_res_in.line_end = push && (push_char == ps2sc_pkg::CHAR_CR);
      p_res_in.char_valid = pop;

      wr_ptr_in = wr_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end

      cnt_in = cnt_ff;
      if (push) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop) begin
         cnt_in = cnt_ff - 1'b1;
      end

      p_res_in.fifo_empty = (cnt_in == '0);
      p_res_in.fill_count = 8'(cnt_in);
   end

   // Store write and registered read
   always_ff @(posedge clock) begin
      if (push) begin
         char_mem[wr_ptr_ff] <= push_char;
      end
      if (pop) begin
         rd_data_ff <= char_mem[rd_ptr_ff];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         brk_ff    <= 1'b0;
         shift_ff  <= 1'b0;
         ctrl_ff   <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         brk_ff    <= brk_in;
         shift_ff  <= shift_in;
         ctrl_ff   <= ctrl_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Result stage valid and output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            p_valid_ff <= 1'b1;
         end else if (p_adv) begin
            p_valid_ff <= 1'b0;
         end
         if (p_adv) begin
            o_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            o_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         p_res_ff <= p_res_in;
      end
      if (p_adv) begin
         o_res_ff  <= p_res_ff;
         o_char_ff <= p_res_ff.char_valid ? rd_data_ff : ps2sc_pkg::CHAR_NUL;
      end
   end

   assign rsp_ch.valid        = o_valid_ff;
   assign rsp_ch.char_valid   = o_res_ff.char_valid;
   assign rsp_ch.char_out     = o_char_ff;
   assign rsp_ch.fifo_empty   = o_res_ff.fifo_empty;
   assign rsp_ch.fill_count   = o_res_ff.fill_count;
   assign rsp_ch.ctrl_c_event = o_res_ff.ctrl_c_event;
   assign rsp_ch.line_end     = o_res_ff.line_end;
   assign rsp_ch.overflow     = o_res_ff.overflow;

   // Checks
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty FIFO with unequal pointers");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      (p_valid_ff && p_res_ff.overflow) |-> (cnt_ff == CNT_FULL))
      else $error("overflow flagged while FIFO not full");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (p_valid_ff && o_valid_ff && !rsp_ch.ready))
      else $error("request stalled with room in the pipe");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      accept |=> (cnt_ff <= CNT_FULL))
      else $error("FIFO count beyond depth");

endmodule
